// ===== hdl/bounded_partition_counter_defines.svh =====
// assertion macros used by the checker file
`ifndef BOUNDED_PARTITION_COUNTER_DEFINES_SVH
`define BOUNDED_PARTITION_COUNTER_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge
`define BPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on the rising clock edge
`define BPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bpc_pkg.sv =====
package bpc_pkg;

    // field widths
    localparam int PART_W = 10;
    localparam int WAY_W  = 32;

    // saturation limit of a table entry
    localparam logic [WAY_W-1:0] WAY_LIMIT = {WAY_W{1'b1}};
    localparam logic [WAY_W-1:0] WAY_ONE   = WAY_W'(1);
    localparam logic [WAY_W-1:0] WAY_ZERO  = '0;

    // request beat
    typedef struct packed {
        logic [PART_W-1:0] largest_part;
        logic [PART_W-1:0] target_sum;
    } t_bpc_in;

    // result beat
    typedef struct packed {
        logic [WAY_W-1:0] way_count;
        logic             saturated;
    } t_bpc_out;

    // sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CLEAR = 5'b00010,
        ST_RUN   = 5'b00100,
        ST_FETCH = 5'b01000,
        ST_RESP  = 5'b10000
    } t_state;

endpackage

// ===== hdl/bpc_table.sv =====
module bpc_table
    import bpc_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WAY_W-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WAY_W-1:0]         o_rd_a,
    output logic [WAY_W-1:0]         o_rd_b
);

    logic [WAY_W-1:0] r_mem [DEPTH];
    logic [WAY_W-1:0] r_rd_a;
    logic [WAY_W-1:0] r_rd_b;
    logic [WAY_W-1:0] r_wlast;
    logic             r_fa;
    logic             r_fb;

    // one write port, two read ports, read-first
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_a <= r_mem[i_rd_addr_a];
        r_rd_b <= r_mem[i_rd_addr_b];
    end

    // note reads that collide with the write of the same edge
    always_ff @(posedge i_clk) begin
        r_wlast <= i_wr_data;
        r_fa    <= i_wr_en && (i_wr_addr == i_rd_addr_a);
        r_fb    <= i_wr_en && (i_wr_addr == i_rd_addr_b);
    end

    // forward the fresh value over the stale read
    assign o_rd_a = r_fa ? r_wlast : r_rd_a;
    assign o_rd_b = r_fb ? r_wlast : r_rd_b;

endmodule

// ===== hdl/bounded_partition_counter.sv =====
// one request at a time: busy stays high until the result, and the next start is taken
//   in the cycle the result beat shows; the table takes one update per cycle while running
// reset: synchronous active-low i_rst_n clears the sequencer, flag and strobe
// the receiver cannot stall: the result beat stands on the ports for one cycle
module bounded_partition_counter
    import bpc_pkg::*;
#(
    parameter int MAX_SUM = 1023
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_bpc_in  i_req,
    output logic     o_strobe,
    output t_bpc_out o_result
);

    localparam int AW = $clog2(MAX_SUM + 1);
    localparam int CW = (AW > PART_W) ? AW : PART_W;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_SUM);

    t_state r_state, n_state;
    logic [AW-1:0] r_s, n_s;
    logic [AW-1:0] r_k, n_k;
    logic [AW-1:0] r_i, n_i;
    logic [AW-1:0] r_j, n_j;
    logic          r_p_v;
    logic [AW-1:0] r_p_addr;
    logic          r_ovf;
    logic          r_strobe;
    t_bpc_out      r_result;

    logic [CW-1:0]    w_tgt;
    logic [CW-1:0]    w_kx;
    logic [AW-1:0]    w_s;
    logic [AW-1:0]    w_k;
    logic             w_accept;
    logic             w_wr_en;
    logic [AW-1:0]    w_wr_addr;
    logic [WAY_W-1:0] w_wr_data;
    logic [AW-1:0]    w_rd_addr_a;
    logic [AW-1:0]    w_rd_addr_b;
    logic [WAY_W-1:0] w_rd_a;
    logic [WAY_W-1:0] w_rd_b;
    logic [WAY_W:0]   w_sum;
    logic             w_sat;
    logic [WAY_W-1:0] w_upd;

    assign w_accept = start && !busy;
    assign busy     = (r_state != ST_IDLE);

    // clamp target to the table and the part to the target
    always_comb begin
        w_tgt = CW'(i_req.target_sum);
        w_s   = (w_tgt > MAX_C) ? AW'(MAX_C) : AW'(w_tgt);
        w_kx  = CW'(i_req.largest_part);
        w_k   = (w_kx > CW'(w_s)) ? w_s : AW'(w_kx);
    end

    // saturating add of the two forwarded reads
    always_comb begin
        w_sum = {1'b0, w_rd_a} + {1'b0, w_rd_b};
        w_sat = (w_sum >= {1'b0, WAY_LIMIT});
        w_upd = w_sat ? WAY_LIMIT : w_sum[WAY_W-1:0];
    end

    // write port: clear sweep or pipeline write-back
    always_comb begin
        if (r_state == ST_CLEAR) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_j;
            w_wr_data = (r_j == '0) ? WAY_ONE : WAY_ZERO;
        end else begin
            w_wr_en   = r_p_v;
            w_wr_addr = r_p_addr;
            w_wr_data = w_upd;
        end
    end

    // read ports: table[j] and table[j-i], or table[S] at the end
    assign w_rd_addr_a = (r_state == ST_FETCH) ? r_s : r_j;
    assign w_rd_addr_b = r_j - r_i;

    bpc_table #(
        .DEPTH(MAX_SUM + 1)
    ) u_table (
        .i_clk       (i_clk),
        .i_wr_en     (w_wr_en),
        .i_wr_addr   (w_wr_addr),
        .i_wr_data   (w_wr_data),
        .i_rd_addr_a (w_rd_addr_a),
        .i_rd_addr_b (w_rd_addr_b),
        .o_rd_a      (w_rd_a),
        .o_rd_b      (w_rd_b)
    );

    // sequencer next state and loop counters
    always_comb begin
        n_state = r_state;
        n_s     = r_s;
        n_k     = r_k;
        n_i     = r_i;
        n_j     = r_j;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_CLEAR;
                    n_s     = w_s;
                    n_k     = w_k;
                    n_j     = '0;
                end
            end
            ST_CLEAR: begin
                if (r_j == r_s) begin
                    n_i = AW'(1);
                    n_j = AW'(1);
                    n_state = (r_k == '0) ? ST_FETCH : ST_RUN;
                end else begin
                    n_j = r_j + AW'(1);
                end
            end
            ST_RUN: begin
                if (r_j == r_s) begin
                    if (r_i == r_k) begin
                        n_state = ST_FETCH;
                    end else begin
                        n_i = r_i + AW'(1);
                        n_j = r_i + AW'(1);
                    end
                end else begin
                    n_j = r_j + AW'(1);
                end
            end
            ST_FETCH: begin
                n_state = ST_RESP;
            end
            ST_RESP: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_p_v    <= 1'b0;
            r_ovf    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_p_v    <= (r_state == ST_RUN);
            r_strobe <= (r_state == ST_RESP);
            if (w_accept) begin
                r_ovf <= 1'b0;
            end else if (r_p_v && w_sat) begin
                r_ovf <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_s      <= n_s;
        r_k      <= n_k;
        r_i      <= n_i;
        r_j      <= n_j;
        r_p_addr <= r_j;
        if (r_state == ST_RESP) begin
            r_result.way_count <= w_rd_a;
            r_result.saturated <= r_ovf;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ===== hdl/bpc_checker.sv =====
`include "bounded_partition_counter_defines.svh"

module bpc_checker
    import bpc_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     start,
    input logic     busy,
    input t_bpc_in  i_req,
    input logic     o_strobe,
    input t_bpc_out o_result
);

    logic w_accept;
    assign w_accept = start && !busy;

    // an accepted beat makes the block busy
    `BPC_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_accept, busy, "busy missing after accept")

    // a result only shows once the block is free again
    `BPC_ASSERT_NOW(a_strobe_idle, i_clk, i_rst_n, o_strobe, !busy, "strobe while busy")

    // no result beat is held: the strobe falls again after each one
    `BPC_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_strobe, !o_strobe, "strobe held twice")

    // finishing a request always delivers its result
    `BPC_ASSERT_NOW(a_done_strobe, i_clk, i_rst_n, $fell(busy), o_strobe, "busy fell with no result")

    // result bits settle on a known value with the strobe
    `BPC_ASSERT_NOW(a_result_known, i_clk, i_rst_n, o_strobe,
        !$isunknown(o_result), "unknown result beat")

endmodule

bind bounded_partition_counter bpc_checker u_bpc_checker (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import bpc_pkg::*;

    localparam int MAX_SUM  = 1023;
    localparam int PLAN_LEN = 17;
    localparam int RAND_LEN = 100;
    localparam int QUIET_AT = 80;

    // results that can be read straight off the request, and a blank for the other rows
    localparam t_bpc_out ONE_WAY  = '{way_count: WAY_ONE, saturated: 1'b0};
    localparam t_bpc_out NO_WAY   = '{way_count: WAY_ZERO, saturated: 1'b0};
    localparam t_bpc_out PINNED   = '{way_count: WAY_LIMIT, saturated: 1'b1};
    localparam t_bpc_out UNTYPED  = '0;

    // one row of the directed plan
    typedef struct packed {
        logic [PART_W-1:0] part;
        logic [PART_W-1:0] target;
        logic              typed;
        t_bpc_out          want;
    } t_plan_row;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start   = 1'b0;
    t_bpc_in  i_req   = '0;
    logic     busy;
    logic     o_strobe;
    t_bpc_out o_result;

    t_bpc_out pending_counts[$];
    int       cycle_count  = 0;
    int       cycle_budget = 2000;
    int       bad_beats    = 0;
    int       checked      = 0;
    int       pinned_seen  = 0;
    int       issued       = 0;

    // zero part, zero target, parts above target, saturation, both field extremes
    t_plan_row plan [PLAN_LEN] = '{
        '{10'd0,    10'd0,    1'b1, ONE_WAY},
        '{10'd0,    10'd7,    1'b1, NO_WAY},
        '{10'd0,    10'd1023, 1'b1, NO_WAY},
        '{10'd9,    10'd0,    1'b1, ONE_WAY},
        '{10'd1023, 10'd0,    1'b1, ONE_WAY},
        '{10'd1,    10'd1,    1'b1, ONE_WAY},
        '{10'd1,    10'd1023, 1'b1, ONE_WAY},
        '{10'd2,    10'd4,    1'b0, UNTYPED},
        '{10'd5,    10'd3,    1'b0, UNTYPED},
        '{10'd1023, 10'd5,    1'b0, UNTYPED},
        '{10'd1023, 10'd2,    1'b0, UNTYPED},
        '{10'd12,   10'd12,   1'b0, UNTYPED},
        '{10'd3,    10'd700,  1'b0, UNTYPED},
        '{10'd127,  10'd127,  1'b0, UNTYPED},
        '{10'd128,  10'd128,  1'b0, UNTYPED},
        '{10'd1023, 10'd140,  1'b0, UNTYPED},
        '{10'd1023, 10'd1023, 1'b1, PINNED}
    };

    bounded_partition_counter #(
        .MAX_SUM (MAX_SUM)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // partition count with parts 1..k, each table entry pinned at the limit
    function automatic t_bpc_out partition_count(input logic [PART_W-1:0] part,
                                                 input logic [PART_W-1:0] target);
        logic [WAY_W-1:0] ways [0:MAX_SUM];
        logic [WAY_W:0]   total;
        int               s;
        int               k;
        t_bpc_out         r;
        s = (int'(target) > MAX_SUM) ? MAX_SUM : int'(target);
        k = (int'(part) > s) ? s : int'(part);
        for (int j = 0; j <= s; j++) ways[j] = WAY_ZERO;
        ways[0] = WAY_ONE;
        r.saturated = 1'b0;
        for (int i = 1; i <= k; i++) begin
            for (int j = i; j <= s; j++) begin
                total = {1'b0, ways[j]} + {1'b0, ways[j-i]};
                if (total >= {1'b0, WAY_LIMIT}) begin
                    total       = {1'b0, WAY_LIMIT};
                    r.saturated = 1'b1;
                end
                ways[j] = total[WAY_W-1:0];
            end
        end
        r.way_count = ways[s];
        return r;
    endfunction

    // cycles from start to strobe for one request
    function automatic int run_cycles(input logic [PART_W-1:0] part,
                                      input logic [PART_W-1:0] target);
        int s;
        int k;
        s = (int'(target) > MAX_SUM) ? MAX_SUM : int'(target);
        k = (int'(part) > s) ? s : int'(part);
        return 4 + s + k * (s + 1) - (k * (k + 1)) / 2;
    endfunction

    // present one request beat, wait until the block is no longer busy, queue its count
    task automatic issue(input logic [PART_W-1:0] part, input logic [PART_W-1:0] target,
                         input t_bpc_out want, input bit may_idle);
        int gap;
        if (may_idle && $urandom_range(0, 3) == 0) begin
            gap   = $urandom_range(1, 16);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cycle_budget += 4 * (run_cycles(part, target) + 40);
        start <= 1'b1;
        i_req <= '{largest_part: part, target_sum: target};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_counts.push_back(want);
        issued++;
    endtask

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > cycle_budget) begin
            $display("%0t timeout after %0d cycles, %0d counts outstanding",
                     $time, cycle_count, pending_counts.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // compare each result beat with the oldest queued count
    always @(posedge i_clk) begin
        t_bpc_out want;
        if (i_rst_n && o_strobe) begin
            if (pending_counts.size() == 0) begin
                $display("%0t unexpected result beat: way_count %0d saturated %0b",
                         $time, o_result.way_count, o_result.saturated);
                bad_beats++;
            end else begin
                want = pending_counts.pop_front();
                checked++;
                if (o_result.saturated) pinned_seen++;
                if (o_result.way_count !== want.way_count) begin
                    $display("%0t way_count: expected %0d, actual %0d",
                             $time, want.way_count, o_result.way_count);
                    bad_beats++;
                end
                if (o_result.saturated !== want.saturated) begin
                    $display("%0t saturated: expected %0b, actual %0b",
                             $time, want.saturated, o_result.saturated);
                    bad_beats++;
                end
            end
        end
    end

    // stimulus
    initial begin
        logic [PART_W-1:0] part;
        logic [PART_W-1:0] target;
        int                pick;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows
        for (int r = 0; r < PLAN_LEN; r++) begin
            issue(plan[r].part, plan[r].target,
                  plan[r].typed ? plan[r].want : partition_count(plan[r].part, plan[r].target),
                  1'b1);
        end

        // random rows, mostly small targets so the run stays short
        for (int n = 0; n < RAND_LEN; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                target = PART_W'($urandom_range(0, 40));
                part   = ($urandom_range(0, 1) == 0) ? PART_W'($urandom_range(0, 1023))
                                                     : PART_W'($urandom_range(0, 42));
            end else if (pick < 93) begin
                target = PART_W'($urandom_range(41, 160));
                part   = ($urandom_range(0, 1) == 0) ? PART_W'($urandom_range(0, 1023))
                                                     : PART_W'($urandom_range(0, 160));
            end else begin
                target = PART_W'($urandom_range(161, 1023));
                part   = PART_W'($urandom_range(0, 6));
            end
            issue(part, target, partition_count(part, target), n < QUIET_AT);
        end
        start <= 1'b0;

        // drain
        while (pending_counts.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("%0d requests issued, %0d results checked in %0d cycles",
                 issued, checked, cycle_count);
        $display("%0d results hit the 32-bit saturation limit", pinned_seen);
        if (bad_beats == 0 && pending_counts.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
